FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; clock i_clk and active-low reset i_rst_n are assumed in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WCDI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define WCDI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/wcdi_pkg.sv
// shared types and constants of the windowed coherent diffuse intensity block
// no dependencies
package wcdi_pkg;

    localparam int IN_W  = 112;
    localparam int OUT_W = 64;
    localparam int CFG_W = 24;

    // configuration register indexes
    localparam logic CFG_RECIP_X = 1'b0;
    localparam logic CFG_RECIP_Y = 1'b1;

    localparam logic [62:0] OUT_MAX      = {63{1'b1}};
    localparam logic [32:0] HANN_GAIN    = 33'd2649351758;
    localparam logic [39:0] SQRT_OUT_MAX = 40'd3037000499;

    // one strobe per datapath step
    typedef struct packed {
        logic load;
        logic ph;
        logic ix;
        logic rd;
        logic w1;
        logic w2;
        logic co;
        logic ac;
        logic sq;
        logic sm;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_sts;

endpackage

FILE: rtl/wcdi_ctrl.sv
// sequencer of the intensity block: steps one item through the datapath
// depends on wcdi_pkg
module wcdi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic            i_m_tready,
    output logic            o_m_tvalid,
    input  wcdi_pkg::t_sts  i_sts,
    output wcdi_pkg::t_cmd  o_cmd
);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_PH   = 11'b000_0000_0010,
        ST_IX   = 11'b000_0000_0100,
        ST_RD   = 11'b000_0000_1000,
        ST_W1   = 11'b000_0001_0000,
        ST_W2   = 11'b000_0010_0000,
        ST_CO   = 11'b000_0100_0000,
        ST_AC   = 11'b000_1000_0000,
        ST_SQ   = 11'b001_0000_0000,
        ST_SM   = 11'b010_0000_0000,
        ST_FIN  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_fin_fire;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign w_accept   = i_s_tvalid && (r_state == ST_IDLE);
    // result slot is free when empty or being taken this cycle
    assign w_fin_fire = (r_state == ST_FIN) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_PH;
            ST_PH:   n_state = ST_IX;
            ST_IX:   n_state = ST_RD;
            ST_RD:   n_state = ST_W1;
            ST_W1:   n_state = ST_W2;
            ST_W2:   n_state = ST_CO;
            ST_CO:   n_state = ST_AC;
            ST_AC:   n_state = i_sts.last ? ST_SQ : ST_IDLE;
            ST_SQ:   n_state = ST_SM;
            ST_SM:   n_state = ST_FIN;
            ST_FIN:  if (w_fin_fire) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fin_fire) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        o_cmd.load = w_accept;
        o_cmd.ph   = (r_state == ST_PH);
        o_cmd.ix   = (r_state == ST_IX);
        o_cmd.rd   = (r_state == ST_RD);
        o_cmd.w1   = (r_state == ST_W1);
        o_cmd.w2   = (r_state == ST_W2);
        o_cmd.co   = (r_state == ST_CO);
        o_cmd.ac   = (r_state == ST_AC);
        o_cmd.sq   = (r_state == ST_SQ);
        o_cmd.sm   = (r_state == ST_SM);
        o_cmd.fin  = w_fin_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/wcdi_dp.sv
// datapath of the intensity block: cosine rom, products, saturating accumulators
// depends on wcdi_pkg; driven step by step by wcdi_ctrl
module wcdi_dp #(
    parameter int COSINE_TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wcdi_pkg::t_cmd              i_cmd,
    output wcdi_pkg::t_sts              o_sts,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [wcdi_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [wcdi_pkg::IN_W-1:0]   i_s_tdata,
    input  logic                        i_s_tlast,
    output logic [62:0]                 o_intensity,
    output logic                        o_overflow
);

    localparam int IW = $clog2(COSINE_TABLE_DEPTH);
    localparam logic [IW:0] DEPTH_V = (IW+1)'(COSINE_TABLE_DEPTH);
    localparam logic [63:0] Q30 = 64'd1073741824;

    typedef logic signed [31:0] t_rom [COSINE_TABLE_DEPTH];

    // one period of cosine, Q1.30, Taylor series on the folded quadrant
    function automatic t_rom build_rom();
        t_rom               rom;
        logic [63:0]        f;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] c;
        logic               neg;
        for (int k = 0; k < COSINE_TABLE_DEPTH; k++) begin
            f   = (64'(k) << 32) / 64'(COSINE_TABLE_DEPTH);
            neg = 1'b0;
            if (f > 64'h8000_0000) f = 64'h1_0000_0000 - f;
            if (f > 64'h4000_0000) begin
                f   = 64'h8000_0000 - f;
                neg = 1'b1;
            end
            x  = (f * 64'd6746518852) >> 32;
            x2 = (x * x) >> 30;
            t  = Q30;
            t  = Q30 - ((x2 * t) >> 30) / 64'd182;
            t  = Q30 - ((x2 * t) >> 30) / 64'd132;
            t  = Q30 - ((x2 * t) >> 30) / 64'd90;
            t  = Q30 - ((x2 * t) >> 30) / 64'd56;
            t  = Q30 - ((x2 * t) >> 30) / 64'd30;
            t  = Q30 - ((x2 * t) >> 30) / 64'd12;
            c  = $signed(Q30 - ((x2 * t) >> 30) / 64'd2);
            if (c < 64'sd0) c = 64'sd0;
            if (c > 64'sd1073741824) c = 64'sd1073741824;
            rom[k] = neg ? -32'(c) : 32'(c);
        end
        return rom;
    endfunction

    localparam t_rom COS_ROM = build_rom();

    // configuration
    logic [23:0] r_rx, r_ry;

    // item registers
    logic [15:0]        r_a;
    logic signed [23:0] r_px, r_py, r_fr, r_fi;
    logic               r_last;

    // step registers
    logic [24:0]        r_ux, r_uy;
    logic signed [40:0] r_afr, r_afi;
    logic signed [47:0] r_fsq_r, r_fsq_i;
    logic signed [55:0] r_pp_r, r_pp_i;
    logic [IW-1:0]      r_idx_x, r_idx_y;
    logic [47:0]        r_self;
    logic signed [42:0] r_ps;
    logic signed [31:0] r_cx, r_cy;
    logic signed [58:0] r_pair;
    logic signed [31:0] r_cc;
    logic signed [23:0] r_h;
    logic signed [44:0] r_tre, r_tim;
    logic [63:0]        r_sq_r, r_sq_i;
    logic               r_sqov;
    logic [62:0]        r_tot;
    logic               r_tsat;

    // list state
    logic signed [55:0] r_coh_re, r_coh_im;
    logic signed [47:0] r_ws_re, r_ws_im;
    logic signed [63:0] r_diff;
    logic               r_satf;

    // output item
    logic [62:0]        r_int;
    logic               r_ovf;

    logic signed [16:0] w_sa;
    logic [48:0]        w_mx, w_my;
    logic signed [31:0] w_sr, w_si;
    logic [47:0]        w_fsum;
    logic [63:0]        w_self;
    logic [40:0]        w_phx, w_phy;
    logic [IW:0]        w_rx, w_ry;
    logic signed [56:0] w_psum;
    logic signed [59:0] w_pair;
    logic signed [63:0] w_cc;
    logic signed [64:0] w_h;
    logic signed [64:0] w_tre, w_tim;

    assign w_sa = $signed({1'b0, r_a});
    assign w_mx = 49'({r_px[23], r_px}) * 49'(r_rx);
    assign w_my = 49'({r_py[23], r_py}) * 49'(r_ry);
    assign w_sr = 32'(r_ws_re >>> 16);
    assign w_si = 32'(r_ws_im >>> 16);
    assign w_fsum = 48'($unsigned(r_fsq_r)) + 48'($unsigned(r_fsq_i));
    assign w_self = 64'(r_a) * 64'(w_fsum);
    // rounded table index, a full turn wraps to entry zero
    assign w_phx = 41'(r_ux) * 41'(COSINE_TABLE_DEPTH) + 41'd16777216;
    assign w_phy = 41'(r_uy) * 41'(COSINE_TABLE_DEPTH) + 41'd16777216;
    assign w_rx = w_phx[25 +: IW+1];
    assign w_ry = w_phy[25 +: IW+1];
    assign w_psum = 57'(r_pp_r) + 57'(r_pp_i);
    assign w_pair = 60'(r_ps) * 60'(w_sa);
    assign w_cc = 64'(r_cx) * 64'(r_cy);
    assign w_h = 65'(r_cc) * 65'($signed(wcdi_pkg::HANN_GAIN));
    assign w_tre = 65'(r_afr) * 65'(r_h);
    assign w_tim = 65'(r_afi) * 65'(r_h);

    // saturating accumulator sums
    logic signed [63:0] w_dadd;
    logic signed [64:0] w_dsum;
    logic signed [63:0] n_diff;
    logic               w_dsat;
    logic signed [56:0] w_cre_sum, w_cim_sum;
    logic signed [55:0] n_coh_re, n_coh_im;
    logic               w_cre_sat, w_cim_sat;
    logic signed [48:0] w_wre_sum, w_wim_sum;
    logic signed [47:0] n_ws_re, n_ws_im;
    logic               w_wre_sat, w_wim_sat;

    assign w_dadd = i_cmd.w1 ? 64'($signed({1'b0, r_self})) : 64'(r_pair);
    assign w_dsum = 65'(r_diff) + 65'(w_dadd);
    assign w_dsat = w_dsum[64] != w_dsum[63];
    assign n_diff = w_dsat ? (w_dsum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                           : w_dsum[63:0];

    assign w_cre_sum = 57'(r_coh_re) + 57'(r_tre);
    assign w_cim_sum = 57'(r_coh_im) + 57'(r_tim);
    assign w_cre_sat = w_cre_sum[56] != w_cre_sum[55];
    assign w_cim_sat = w_cim_sum[56] != w_cim_sum[55];
    assign n_coh_re = w_cre_sat ? (w_cre_sum[56] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}})
                                : w_cre_sum[55:0];
    assign n_coh_im = w_cim_sat ? (w_cim_sum[56] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}})
                                : w_cim_sum[55:0];

    assign w_wre_sum = 49'(r_ws_re) + 49'(r_afr);
    assign w_wim_sum = 49'(r_ws_im) + 49'(r_afi);
    assign w_wre_sat = w_wre_sum[48] != w_wre_sum[47];
    assign w_wim_sat = w_wim_sum[48] != w_wim_sum[47];
    assign n_ws_re = w_wre_sat ? (w_wre_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                               : w_wre_sum[47:0];
    assign n_ws_im = w_wim_sat ? (w_wim_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                               : w_wim_sum[47:0];

    // result stage
    logic signed [39:0] w_cr, w_ci;
    logic [39:0]        w_mr, w_mi;
    logic               w_ovr, w_ovi;
    logic [63:0]        w_tot;
    logic               w_tov;
    logic [62:0]        w_dpos;
    logic               w_fsat;

    assign w_cr  = 40'(r_coh_re >>> 16);
    assign w_ci  = 40'(r_coh_im >>> 16);
    assign w_mr  = w_cr[39] ? 40'(-w_cr) : 40'(w_cr);
    assign w_mi  = w_ci[39] ? 40'(-w_ci) : 40'(w_ci);
    assign w_ovr = w_mr > wcdi_pkg::SQRT_OUT_MAX;
    assign w_ovi = w_mi > wcdi_pkg::SQRT_OUT_MAX;
    assign w_tot = r_sq_r + r_sq_i;
    assign w_tov = w_tot > {1'b0, wcdi_pkg::OUT_MAX};
    // a negative diffuse sum counts as zero
    assign w_dpos = r_diff[63] ? 63'd0 : r_diff[62:0];
    assign w_fsat = w_dpos > (wcdi_pkg::OUT_MAX - r_tot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx <= 24'd1;
            r_ry <= 24'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wcdi_pkg::CFG_RECIP_X: r_rx <= i_cfg_data;
                wcdi_pkg::CFG_RECIP_Y: r_ry <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= i_s_tdata[15:0];
            r_px   <= i_s_tdata[39:16];
            r_py   <= i_s_tdata[63:40];
            r_fr   <= i_s_tdata[87:64];
            r_fi   <= i_s_tdata[111:88];
            r_last <= i_s_tlast;
        end
        if (i_cmd.ph) begin
            r_ux    <= w_mx[24:0];
            r_uy    <= w_my[24:0];
            r_afr   <= 41'(w_sa) * 41'(r_fr);
            r_afi   <= 41'(w_sa) * 41'(r_fi);
            r_fsq_r <= 48'(r_fr) * 48'(r_fr);
            r_fsq_i <= 48'(r_fi) * 48'(r_fi);
            r_pp_r  <= 56'(r_fr) * 56'(w_sr);
            r_pp_i  <= 56'(r_fi) * 56'(w_si);
        end
        if (i_cmd.ix) begin
            r_idx_x <= (w_rx == DEPTH_V) ? '0 : w_rx[IW-1:0];
            r_idx_y <= (w_ry == DEPTH_V) ? '0 : w_ry[IW-1:0];
            r_self  <= w_self[63:16];
            r_ps    <= 43'(w_psum >>> 14);
        end
        if (i_cmd.rd) begin
            r_cx   <= COS_ROM[r_idx_x];
            r_cy   <= COS_ROM[r_idx_y];
            r_pair <= 59'(w_pair >>> 1);
        end
        if (i_cmd.w1) begin
            r_cc <= 32'(w_cc >>> 30);
        end
        if (i_cmd.w2) begin
            r_h <= 24'(w_h >>> 40);
        end
        if (i_cmd.co) begin
            r_tre <= 45'(w_tre >>> 20);
            r_tim <= 45'(w_tim >>> 20);
        end
        if (i_cmd.sq) begin
            r_sq_r <= w_ovr ? {1'b0, wcdi_pkg::OUT_MAX} : 64'(w_mr[31:0]) * 64'(w_mr[31:0]);
            r_sq_i <= w_ovi ? {1'b0, wcdi_pkg::OUT_MAX} : 64'(w_mi[31:0]) * 64'(w_mi[31:0]);
            r_sqov <= w_ovr | w_ovi;
        end
        if (i_cmd.sm) begin
            r_tot  <= w_tov ? wcdi_pkg::OUT_MAX : w_tot[62:0];
            r_tsat <= r_sqov | w_tov;
        end
        if (i_cmd.fin) begin
            r_int <= w_fsat ? wcdi_pkg::OUT_MAX : r_tot + w_dpos;
            r_ovf <= r_satf | r_tsat | w_fsat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.fin) begin
            r_coh_re <= '0;
            r_coh_im <= '0;
            r_ws_re  <= '0;
            r_ws_im  <= '0;
            r_diff   <= '0;
            r_satf   <= 1'b0;
        end else begin
            if (i_cmd.w1 || i_cmd.w2) begin
                r_diff <= n_diff;
                if (w_dsat) r_satf <= 1'b1;
            end
            if (i_cmd.co) begin
                r_ws_re <= n_ws_re;
                r_ws_im <= n_ws_im;
                if (w_wre_sat || w_wim_sat) r_satf <= 1'b1;
            end
            if (i_cmd.ac) begin
                r_coh_re <= n_coh_re;
                r_coh_im <= n_coh_im;
                if (w_cre_sat || w_cim_sat) r_satf <= 1'b1;
            end
        end
    end

    assign o_sts.last  = r_last;
    assign o_intensity = r_int;
    assign o_overflow  = r_ovf;

endmodule

FILE: rtl/windowed_coherent_diffuse_intensity.sv
// channel  | dir | handshake           | payload
// s (in)   | in  | i_s_tvalid/o_s_tready | tdata: particle fields, tlast: end of list
// m (out)  | out | o_m_tvalid/i_m_tready | tdata: intensity, tuser: overflow
// cfg      | in  | i_cfg_we            | i_cfg_idx, i_cfg_data
// the sequencer walks one item through the shared datapath steps: ph, ix, rd, w1, w2, co, ac,
// then back to idle, or through sq, sm and fin when it closes the list (plus any wait for the
// result register), before the next item is accepted. result register frees the input side while a result waits.
// synchronous active-low reset clears the list state and sets both reciprocal registers to 1.
// top level; depends on wcdi_pkg, wcdi_ctrl, wcdi_dp
module windowed_coherent_diffuse_intensity #(
    parameter int COSINE_TABLE_DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [wcdi_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // abundance[15:0], pos_x[39:16], pos_y[63:40], ff_re[87:64], ff_im[111:88]
    input  logic [wcdi_pkg::IN_W-1:0]    i_s_tdata,
    input  logic                         i_s_tlast,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // intensity[62:0], zero pad[63]
    output logic [wcdi_pkg::OUT_W-1:0]   o_m_tdata,
    // overflow[0]
    output logic                         o_m_tuser
);

    wcdi_pkg::t_cmd w_cmd;
    wcdi_pkg::t_sts w_sts;
    logic [62:0]    w_int;

    wcdi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wcdi_dp #(
        .COSINE_TABLE_DEPTH (COSINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_intensity (w_int),
        .o_overflow  (o_m_tuser)
    );

    assign o_m_tdata = {1'b0, w_int};

endmodule

FILE: rtl/wcdi_chk.sv
// port-level checks of the intensity block, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module wcdi_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tuser
);

    // only one item in flight
    `WCDI_ASSERT_NXT(a_one_item, i_s_tvalid && o_s_tready, !o_s_tready)
    // a result appears only out of the final step, when input is not taken
    `WCDI_ASSERT_IMP(a_res_after_fin, $rose(o_m_tvalid), $past(!o_s_tready))
    // stalled result holds
    `WCDI_ASSERT_NXT(a_res_hold, o_m_tvalid && !i_m_tready,
                     o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
    // pad bit above the intensity stays clear
    `WCDI_ASSERT_IMP(a_pad_zero, o_m_tvalid, !o_m_tdata[63])

endmodule

bind windowed_coherent_diffuse_intensity wcdi_chk u_chk (.*);
